@@ src/bdr_pkg.sv @@
// bdr_pkg: types, constants and duty maps for the backlight duty ramp
// no dependencies; used by bdr_div, bdr_core and backlight_duty_ramp
package bdr_pkg;

	localparam int DUTY_W  = 18;
	localparam int LEVEL_W = 8;
	// log2 of the largest ramp step count the divider is sized for
	localparam int STEPS_LOG2_MAX = 10;

	localparam logic [DUTY_W-1:0] DUTY_MAX  = 18'd200000;
	localparam logic [DUTY_W-1:0] DUTY_HIGH = 18'd150000;
	localparam logic [DUTY_W-1:0] DUTY_MID  = 18'd100000;
	localparam logic [DUTY_W-1:0] DUTY_LOW  = 18'd50000;
	localparam logic [DUTY_W-1:0] DUTY_MIN  = 18'd1;

	typedef enum logic [1:0] {
		OP_DIRECT = 2'd0,
		OP_AUTO   = 2'd1,
		OP_RAMP   = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                operation;
		logic [LEVEL_W-1:0] level;
	} req_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              pwm_write;
		logic              at_level;
	} rsp_t;

	// five-entry direct map, only meaningful for levels 1 to 5
	function automatic logic [DUTY_W-1:0] direct_duty(input logic [LEVEL_W-1:0] lv);
		logic [DUTY_W-1:0] v;
		case (lv)
			8'd1: v = DUTY_MAX;
			8'd2: v = DUTY_HIGH;
			8'd3: v = DUTY_MID;
			8'd4: v = DUTY_LOW;
			8'd5: v = DUTY_MIN;
			default: v = '0;
		endcase
		return v;
	endfunction

	// three-value map, anything unlisted goes to full duty
	function automatic logic [DUTY_W-1:0] auto_duty(input logic [LEVEL_W-1:0] lv);
		logic [DUTY_W-1:0] v;
		case (lv) inside
			[8'd2:8'd3]: v = DUTY_MID;
			[8'd4:8'd5]: v = DUTY_MIN;
			default:     v = DUTY_MAX;
		endcase
		return v;
	endfunction

	function automatic logic [DUTY_W-1:0] clamp_duty(input logic [DUTY_W-1:0] v);
		logic [DUTY_W-1:0] r;
		if (v > DUTY_MAX) begin
			r = DUTY_MAX;
		end else if (v < DUTY_MIN) begin
			r = DUTY_MIN;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

@@ src/bdr_div.sv @@
// bdr_div: divides a duty difference by the fixed ramp step count
// reciprocal multiply, exact for every 18-bit dividend; uses bdr_pkg
module bdr_div #(
	parameter int RAMP_STEPS = 80
) (
	input  logic [bdr_pkg::DUTY_W-1:0] dividend,
	output logic [bdr_pkg::DUTY_W-1:0] quotient
);

	localparam int SHIFT  = bdr_pkg::DUTY_W + bdr_pkg::STEPS_LOG2_MAX;
	localparam int MULT_W = SHIFT + 1;
	localparam int PROD_W = bdr_pkg::DUTY_W + MULT_W;
	// rounded-up reciprocal, error per unit stays below 2^-DUTY_W
	localparam logic [MULT_W-1:0] MULT = MULT_W'((64'd1 << SHIFT) / RAMP_STEPS + 1);

	logic [PROD_W-1:0] prod;

	assign prod     = PROD_W'(dividend) * PROD_W'(MULT);
	assign quotient = prod[SHIFT +: bdr_pkg::DUTY_W];

endmodule

@@ src/bdr_core.sv @@
// bdr_core: duty state and the per-request update of direct, auto, ramp and query
// uses bdr_pkg and bdr_div
module bdr_core #(
	parameter int RAMP_STEPS = 80
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  bdr_pkg::req_t req,
	output bdr_pkg::rsp_t rsp
);

	localparam int DW = bdr_pkg::DUTY_W;

	logic [DW-1:0]               current_q, target_q, step_q;
	logic [bdr_pkg::LEVEL_W-1:0] direct_q, auto_q;

	logic [DW-1:0]               current_d, target_d, step_d;
	logic [bdr_pkg::LEVEL_W-1:0] direct_d, auto_d;

	logic [DW-1:0] map_dir, map_auto, cur_c, tgt_c, diff, quo, step_new, step_use;
	logic [DW:0]   up_sum;
	logic          write, hit;

	assign map_dir  = bdr_pkg::direct_duty(req.level);
	assign map_auto = bdr_pkg::auto_duty(req.level);
	assign cur_c    = bdr_pkg::clamp_duty(current_q);
	assign tgt_c    = bdr_pkg::clamp_duty(map_auto);
	assign diff     = (tgt_c >= cur_c) ? (tgt_c - cur_c) : (cur_c - tgt_c);

	bdr_div #(.RAMP_STEPS(RAMP_STEPS)) u_div (
		.dividend(diff),
		.quotient(quo)
	);

	assign step_new = (quo == '0) ? bdr_pkg::DUTY_MIN : quo;
	// old target plays the part of the previous target, so no copy is kept
	assign step_use = (target_q != tgt_c) ? step_new : step_q;
	assign up_sum   = {1'b0, cur_c} + {1'b0, step_use};

	always_comb begin
		current_d = current_q;
		target_d  = target_q;
		step_d    = step_q;
		direct_d  = direct_q;
		auto_d    = auto_q;
		write     = 1'b0;
		hit       = 1'b0;
		case (req.operation)
			bdr_pkg::OP_DIRECT: begin
				if (req.level != direct_q && req.level inside {[8'd1:8'd5]}) begin
					current_d = map_dir;
					target_d  = map_dir;
					direct_d  = req.level;
					write     = 1'b1;
				end
			end
			bdr_pkg::OP_AUTO: begin
				if (req.level != auto_q) begin
					current_d = map_auto;
					target_d  = map_auto;
					auto_d    = req.level;
					write     = 1'b1;
				end
			end
			bdr_pkg::OP_RAMP: begin
				target_d = tgt_c;
				step_d   = step_use;
				write    = 1'b1;
				if (cur_c <= tgt_c) begin
					current_d = (up_sum > {1'b0, tgt_c}) ? tgt_c : up_sum[DW-1:0];
				end else if ((cur_c - tgt_c) < step_use) begin
					current_d = tgt_c;
				end else begin
					current_d = cur_c - step_use;
				end
			end
			bdr_pkg::OP_QUERY: begin
				hit = (map_auto == current_q);
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q <= '0;
			target_q  <= '0;
			step_q    <= '0;
			direct_q  <= '0;
			auto_q    <= '0;
		end else if (en) begin
			current_q <= current_d;
			target_q  <= target_d;
			step_q    <= step_d;
			direct_q  <= direct_d;
			auto_q    <= auto_d;
		end
	end

	assign rsp.duty      = current_d;
	assign rsp.pwm_write = write;
	assign rsp.at_level  = hit;

endmodule

@@ src/backlight_duty_ramp.sv @@
// backlight_duty_ramp: top level, input register, duty update and result register
// uses bdr_pkg and bdr_core
//
// usage
//   request channel: req_valid / req_stall / req_data carry one request,
//   an operation (direct set, auto init, ramp step, query) and a level
//   response channel: rsp_valid / rsp_stall / rsp_data carry one result
//   per request: the duty after the request, a pwm write flag and the
//   query hit flag
//   path: an accepted request is held in the input register, and its result
//   goes from there through the duty update into the result register
//   throughput: one request per cycle while no result is stalled; the duty
//   state is updated in the same cycle that the result register loads, so
//   back to back requests see each other's effect with no bubble
//   the critical path is the clamp, the reciprocal multiply for the step
//   size and the step add and saturate, all between the two registers
//   reset: all duty state, levels and step size clear to zero, and both
//   stages come up empty
//   stall: when rsp_stall holds a result, a full input register holds too
//   and raises req_stall, while an empty input register can still load
module backlight_duty_ramp #(
	parameter int RAMP_STEPS = 80
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bdr_pkg::req_t req_data,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bdr_pkg::rsp_t rsp_data
);

	logic          valid_s1;
	bdr_pkg::req_t req_s1;
	logic          adv_out;   // result register can load this cycle
	logic          take_s1;   // request in the input register is processed
	bdr_pkg::rsp_t rsp_c;

	assign adv_out   = !rsp_valid || !rsp_stall;
	assign take_s1   = valid_s1 && adv_out;
	// input register frees up whenever its request moves on
	assign req_stall = valid_s1 && !adv_out;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!req_stall && req_valid) begin
			req_s1 <= req_data;
		end
	end

	// duty state and per-request update
	bdr_core #(.RAMP_STEPS(RAMP_STEPS)) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (take_s1),
		.req   (req_s1),
		.rsp   (rsp_c)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (adv_out) begin
			rsp_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			rsp_data <= rsp_c;
		end
	end

endmodule
